// ----- sv/hsl_colorize_pixel_defines.svh -----
// Assertion macros for the hsl_colorize_pixel RTL, used by hscp_ctl.
`ifndef HSL_COLORIZE_PIXEL_DEFINES_SVH
`define HSL_COLORIZE_PIXEL_DEFINES_SVH

// Same-cycle implication, off during reset.
`define HSCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hscp: same-cycle check failed");

// Next-cycle implication, off during reset.
`define HSCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hscp: next-cycle check failed");

`endif

// ----- sv/hscp_pkg.sv -----
// Types, constants and helpers for the HSL colorize pixel pipeline.
`default_nettype none

package hscp_pkg;

  localparam int StageCount = 6;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegTintHue = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTintSat = CfgIdxW'(1);

  // floor(n / 195075) == (n * RecipMul) >> RecipShift for every n < 2**26
  localparam longint unsigned ChanDiv    = 195075;
  localparam int              RecipShift = 44;
  localparam logic [26:0]     RecipMul   =
    27'(((64'd1 << RecipShift) + ChanDiv - 64'd1) / ChanDiv);

  typedef struct packed {
    logic [StageCount-1:0] en;   // stage k loads its registers
  } hscp_ctl_t;

  typedef struct packed {
    logic       use_q;   // base term is Q, else P
    logic [6:0] f;       // ramp factor on (Q - P)
  } hscp_sel_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] diff;
    logic [6:0]  f;
  } hscp_chan_in_t;

  // Hue position t (scaled by 765) to the base term and ramp factor.
  function automatic hscp_sel_t hscp_hue_sel(input logic [9:0] t);
    hscp_sel_t  s;
    logic [9:0] back;
    back    = 10'd510 - t;
    s.use_q = 1'b0;
    s.f     = '0;
    priority if (t <= 10'd127) begin
      s.f = t[6:0];
    end else if (t <= 10'd382) begin
      s.use_q = 1'b1;
    end else if (t < 10'd510) begin
      s.f = back[6:0];
    end else begin
      // floor at P, no ramp
      s.f = '0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hscp_if.sv -----
// Channel interfaces: input pixel, output pixel and config write.
`default_nettype none

interface hscp_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface hscp_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface hscp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/hscp_ctl.sv -----
// Valid bits and stall chain for the six pipeline stages.
`default_nettype none
`include "hsl_colorize_pixel_defines.svh"

module hscp_ctl
  import hscp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hscp_ctl_t ctl
);

  logic [StageCount-1:0] v;
  logic [StageCount-1:0] rdy;

  // a stage may load when empty or when the one after it moves
  always_comb begin
    rdy[StageCount-1] = !v[StageCount-1] || out_ready;
    for (int k = StageCount - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
    ctl.en[0] = in_valid && rdy[0];
    for (int k = 1; k < StageCount; k++) begin
      ctl.en[k] = v[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < StageCount; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[StageCount-1];

  `HSCP_ASSERT_NOW(a_full_when_blocked, clk, rst, !rdy[0], &v)
  `HSCP_ASSERT_NEXT(a_accept_lands, clk, rst, ctl.en[0], v[0])
  `HSCP_ASSERT_NEXT(a_result_held, clk, rst, v[StageCount-1] && !out_ready, v[StageCount-1])

endmodule

`default_nettype wire

// ----- sv/hscp_front.sv -----
// Stages 1-3: gray level, hue selection, L*S product, Q and P terms.
`default_nettype none

module hscp_front
  import hscp_pkg::*;
(
  input  logic                clk,
  input  hscp_ctl_t           ctl,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          alpha,
  input  logic [7:0]          hue,
  input  logic [7:0]          sat,
  output hscp_chan_in_t [2:0] chan,
  output logic [7:0]          alpha_out
);

  // stage 1 logic
  logic [12:0] sum;
  logic [9:0]  h3;
  logic [10:0] t_r_raw;
  logic [9:0]  t_r;
  logic [9:0]  t_b;

  always_comb begin
    sum = 13'({red, 3'b0}) + 13'({red, 1'b0}) + 13'(red)
        + 13'({green, 4'b0})
        + 13'({blue, 2'b0}) + 13'(blue);
    h3      = 10'({hue, 1'b0}) + 10'(hue);
    t_r_raw = 11'(h3) + 11'd255;
    t_r     = (t_r_raw > 11'd765) ? 10'(t_r_raw - 11'd765) : t_r_raw[9:0];
    t_b     = (h3 < 10'd255) ? (h3 + 10'd510) : (h3 - 10'd255);
  end

  logic [7:0]            lum1;
  logic [7:0]            sat1;
  logic [7:0]            alpha1;
  hscp_sel_t [2:0]       sel1;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      lum1    <= sum[12:5];
      sat1    <= sat;
      alpha1  <= alpha;
      sel1[0] <= hscp_hue_sel(t_r);
      sel1[1] <= hscp_hue_sel(h3);
      sel1[2] <= hscp_hue_sel(t_b);
    end
  end

  // stage 2: L*S
  logic [7:0]      lum2;
  logic [7:0]      sat2;
  logic [7:0]      alpha2;
  logic [15:0]     ls2;
  hscp_sel_t [2:0] sel2;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      lum2   <= lum1;
      sat2   <= sat1;
      alpha2 <= alpha1;
      ls2    <= {8'b0, lum1} * {8'b0, sat1};
      sel2   <= sel1;
    end
  end

  // stage 3: Q, P and Q-P, all scaled by 255*255
  logic [15:0] l255;
  logic [15:0] s255;
  logic [16:0] l510;
  logic [16:0] q_wide;
  logic [15:0] q;
  logic [15:0] p;
  logic [15:0] d;

  always_comb begin
    l255   = {lum2, 8'b0} - 16'(lum2);
    s255   = {sat2, 8'b0} - 16'(sat2);
    l510   = {lum2, 9'b0} - 17'({lum2, 1'b0});
    q_wide = lum2[7] ? (17'(l255) + 17'(s255) - 17'(ls2)) : (17'(l255) + 17'(ls2));
    q      = q_wide[15:0];
    p      = 16'(l510 - 17'(q));
    d      = q - p;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      alpha_out <= alpha2;
      for (int c = 0; c < 3; c++) begin
        chan[c].base <= sel2[c].use_q ? q : p;
        chan[c].diff <= d;
        chan[c].f    <= sel2[c].f;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/hscp_chan.sv -----
// Stages 4-6 of one color channel: ramp product, numerator, divide by 195075.
`default_nettype none

module hscp_chan
  import hscp_pkg::*;
(
  input  logic          clk,
  input  hscp_ctl_t     ctl,
  input  hscp_chan_in_t cin,
  output logic [7:0]    value
);

  logic [22:0] prod4;
  logic [15:0] base4;
  logic [25:0] num5;
  logic [52:0] full;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      prod4 <= 23'(cin.f) * 23'(cin.diff);
      base4 <= cin.base;
    end
  end

  // 765*base + 6*f*(Q-P), stays below 195075*256
  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      num5 <= 26'(27'(base4) * 27'd765 + 27'(prod4) * 27'd6);
    end
  end

  // reciprocal multiply, exact for 26-bit numerators
  assign full = 53'(num5) * 53'(RecipMul);

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      value <= full[RecipShift +: 8];
    end
  end

endmodule

`default_nettype wire

// ----- sv/hsl_colorize_pixel.sv -----
// Top level of the HSL colorize pixel pipeline.
// Six register stages lie between pixel accept and result valid, one per pipeline step.
// Throughput: one pixel per clock; each stage holds its beat until the next frees up,
// so ready drops only when all six stages are full and the result is not taken.
// Rate is set by the six-stage valid/stall chain; no stage iterates.
// Reset (rst, synchronous): clears all stage valid bits, hue and saturation to 0.
`default_nettype none

module hsl_colorize_pixel
  import hscp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  hscp_cfg_if.sink       cfg,
  hscp_pix_in_if.sink    pixel,
  hscp_pix_out_if.source result
);

  // --- config registers, always ready; unknown indexes are dropped
  logic [7:0] tint_hue;
  logic [7:0] tint_saturation;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_hue        <= '0;
      tint_saturation <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        RegTintHue: tint_hue        <= cfg.data;
        RegTintSat: tint_saturation <= cfg.data;
        default: ;
      endcase
    end
  end

  // --- pipeline control: one valid bit per stage, bubbles collapse on stall
  hscp_ctl_t ctl;

  hscp_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // --- stages 1-3: gray level, hue positions snapshot, Q/P terms
  hscp_chan_in_t [2:0] chan;
  logic [7:0]          alpha3;

  hscp_front u_front (
    .clk       (clk),
    .ctl       (ctl),
    .red       (pixel.in_red),
    .green     (pixel.in_green),
    .blue      (pixel.in_blue),
    .alpha     (pixel.in_alpha),
    .hue       (tint_hue),
    .sat       (tint_saturation),
    .chan      (chan),
    .alpha_out (alpha3)
  );

  // --- stages 4-6: one datapath per color channel (red, green, blue)
  logic [7:0] chan_val [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    hscp_chan u_chan (
      .clk   (clk),
      .ctl   (ctl),
      .cin   (chan[c]),
      .value (chan_val[c])
    );
  end

  // alpha rides along stages 4-6 untouched
  logic [7:0] alpha4;
  logic [7:0] alpha5;
  logic [7:0] alpha6;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) alpha4 <= alpha3;
    if (ctl.en[4]) alpha5 <= alpha4;
    if (ctl.en[5]) alpha6 <= alpha5;
  end

  assign result.out_red   = chan_val[0];
  assign result.out_green = chan_val[1];
  assign result.out_blue  = chan_val[2];
  assign result.out_alpha = alpha6;

endmodule

`default_nettype wire

// ----- test/hsl_colorize_pixel_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for hsl_colorize_pixel: tint prediction, stalls, register writes.
module hsl_colorize_pixel_tb;
  import hscp_pkg::*;

  localparam int CycleLimit = 200000;   // watchdog, far above the slowest legal run
  localparam int HoldCycles = 150;      // long sink hold-off, fills the pipe
  localparam int IdlePct    = 9;        // idle/stall chance per cycle, percent
  localparam int ReportMax  = 10;       // mismatches printed in full
  localparam int PhaseBeats = 50;       // random pixels per register setting
  localparam int PhaseCount = 12;
  localparam int DrainCycles = 12;      // quiet time after the last result

  // indexes past the register list; writes there must not change anything
  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic clk;
  logic rst;

  hscp_cfg_if     cfg_bus ();
  hscp_pix_in_if  pix_in ();
  hscp_pix_out_if pix_out ();

  hsl_colorize_pixel u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixel  (pix_in),
    .result (pix_out)
  );

  rgba_t      pixel_backlog[$];   // pixels waiting to be offered
  rgba_t      tint_expect[$];     // predicted results, oldest first
  logic [7:0] hue_cfg;            // shadow of the tint registers
  logic [7:0] sat_cfg;
  bit         pix_taken;          // set at the edge that accepted the offered pixel
  bit         steady;             // no idling on either side
  bit         hold_req;           // ask the sink for one long hold-off
  int         hold_left;
  int         fail_count;
  int         report_count;
  int         cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One color channel. t is the hue position scaled by 765, p and q are the
  // HSL helper terms scaled by 255*255. Returns the exact value times 255,
  // truncated. The flat sections use 765*q and 765*p so every branch divides
  // by the same 195075 = 765*255.
  function automatic logic [7:0] hue_channel(int t, longint p, longint q);
    longint num;
    if (t < 0) t += 765;
    if (t > 765) t -= 765;       // exactly 765 stays put
    if (2 * t < 255)
      num = 765 * p + 6 * t * (q - p);           // rising ramp
    else if (2 * t < 765)
      num = 765 * q;                              // plateau at q
    else if (t < 510)
      num = 765 * p + 6 * (510 - t) * (q - p);   // falling ramp
    else
      num = 765 * p;                              // floor at p
    return 8'(num / 195075);
  endfunction

  // Full pixel: gray level as lightness, current hue/saturation, alpha copied.
  function automatic rgba_t tint_predict(rgba_t px);
    int     lum;
    int     sat;
    int     h3;
    longint q;
    longint p;
    rgba_t  res;
    lum       = (11 * int'(px.red) + 16 * int'(px.green) + 5 * int'(px.blue)) / 32;
    sat       = int'(sat_cfg);
    h3        = 3 * int'(hue_cfg);
    res.alpha = px.alpha;
    if (sat == 0) begin
      // no saturation: plain gray on all three channels
      res.red   = 8'(lum);
      res.green = 8'(lum);
      res.blue  = 8'(lum);
      return res;
    end
    if (lum <= 127)
      q = lum * (255 + sat);
    else
      q = 255 * lum + 255 * sat - lum * sat;
    p = 510 * lum - q;
    res.red   = hue_channel(h3 + 255, p, q);
    res.green = hue_channel(h3, p, q);
    res.blue  = hue_channel(h3 - 255, p, q);
    return res;
  endfunction

  // Channel level biased toward the ends of the range.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel source: offers the backlog, idles at random between beats.
  // ---------------------------------------------------------------------------

  // Accepted input beat: predict at the edge, so the shadow registers are the
  // ones the block sees for this pixel.
  always @(posedge clk) begin
    if (!rst && pix_in.valid && pix_in.ready) begin
      tint_expect.push_back(tint_predict({pix_in.in_red, pix_in.in_green,
                                          pix_in.in_blue, pix_in.in_alpha}));
      pix_taken = 1'b1;
    end
  end

  // One decision per falling edge: either a new beat, a held beat, or idle.
  // valid gets a single assignment here, so back-to-back beats keep it high.
  always @(negedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
    end else if (!pix_in.valid || pix_taken) begin
      pix_taken = 1'b0;
      if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha}
          <= pixel_backlog.pop_front();
        pix_in.valid <= 1'b1;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= steady || $urandom_range(99) >= IdlePct;
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin : check_beat
      rgba_t want;
      if (tint_expect.size() == 0) begin
        fail_count++;
        if (report_count < ReportMax)
          $display("%0t: result beat with nothing expected: r=%0d g=%0d b=%0d a=%0d",
                   $realtime, pix_out.out_red, pix_out.out_green,
                   pix_out.out_blue, pix_out.out_alpha);
        report_count++;
      end else begin
        want = tint_expect.pop_front();
        if (pix_out.out_red !== want.red || pix_out.out_green !== want.green ||
            pix_out.out_blue !== want.blue || pix_out.out_alpha !== want.alpha) begin
          fail_count++;
          if (report_count < ReportMax)
            $display("%0t: mismatch hue=%0d sat=%0d exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                     $realtime, hue_cfg, sat_cfg, want.red, want.green, want.blue,
                     want.alpha, pix_out.out_red, pix_out.out_green,
                     pix_out.out_blue, pix_out.out_alpha);
          report_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and idle detection
  // ---------------------------------------------------------------------------

  // Write one register; the shadow copy follows at the accepting edge.
  // Out-of-range indexes leave the shadow alone, as they must the block.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == RegTintHue)
      hue_cfg = val;
    else if (idx == RegTintSat)
      sat_cfg = val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Block until nothing is queued, offered or outstanding. Sampled on the
  // rising edge: backlog and valid only move on the falling edge, and an
  // expectation can only be added while valid is high.
  task automatic drain();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || pix_in.valid || tint_expect.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    pix_in.valid    = 1'b0;
    pix_in.in_red   = '0;
    pix_in.in_green = '0;
    pix_in.in_blue  = '0;
    pix_in.in_alpha = '0;
    pix_out.ready   = 1'b0;
    hue_cfg         = '0;
    sat_cfg         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset registers: zero saturation, every pixel comes back gray.
    pixel_backlog.push_back({8'd0, 8'd0, 8'd0, 8'd0});
    pixel_backlog.push_back({8'd255, 8'd255, 8'd255, 8'd255});
    pixel_backlog.push_back({8'd255, 8'd0, 8'd0, 8'h5A});
    pixel_backlog.push_back({8'd0, 8'd255, 8'd0, 8'hA5});
    pixel_backlog.push_back({8'd0, 8'd0, 8'd255, 8'h3C});
    drain();

    // Full saturation, hue 0: lightness on both sides of one half.
    cfg_write(RegTintSat, 8'd255);
    pixel_backlog.push_back({8'd127, 8'd127, 8'd127, 8'd1});
    pixel_backlog.push_back({8'd128, 8'd128, 8'd128, 8'd2});
    pixel_backlog.push_back({8'd0, 8'd0, 8'd0, 8'd254});
    pixel_backlog.push_back({8'd255, 8'd255, 8'd255, 8'd128});
    drain();

    // Top of the hue circle.
    cfg_write(RegTintHue, 8'd255);
    pixel_backlog.push_back({8'd200, 8'd100, 8'd50, 8'd77});
    pixel_backlog.push_back({8'd30, 8'd220, 8'd90, 8'd200});
    drain();

    // Hue near a ramp corner, weakest nonzero saturation.
    cfg_write(RegTintHue, 8'd42);
    cfg_write(RegTintSat, 8'd1);
    pixel_backlog.push_back({8'd64, 8'd192, 8'd16, 8'd33});
    pixel_backlog.push_back({8'd250, 8'd5, 8'd180, 8'd99});
    drain();

    // Writes past the register list are dropped; tint must stay as it was.
    cfg_write(RegTintHue, 8'd170);
    cfg_write(RegTintSat, 8'd128);
    cfg_write(RegSpareA, 8'hFF);
    cfg_write(RegSpareB, 8'h00);
    pixel_backlog.push_back({8'd100, 8'd150, 8'd200, 8'd10});
    pixel_backlog.push_back({8'd90, 8'd40, 8'd10, 8'd240});
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      cfg_write(RegTintHue, ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : 8'($urandom_range(255)));
      cfg_write(RegTintSat, ph == 2 ? 8'd0 : ph == 3 ? 8'd255 :
                            ph == 4 ? 8'd1 : 8'($urandom_range(1, 255)));
      if (ph == 5)
        cfg_write($urandom_range(1) ? RegSpareA : RegSpareB, 8'($urandom));
      steady = (ph == 7);          // one phase at full rate on both sides
      if (ph == 9) begin
        // sink goes quiet while the source keeps offering: pipe fills, input stalls
        @(posedge clk);
        hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseBeats; n++)
        pixel_backlog.push_back({rand_level(), rand_level(), rand_level(), rand_level()});
      drain();
    end
    steady = 1'b0;

    // Anything after this point would be a stray result.
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
